// File: rtl/core/ttriu_pkg.sv
// ----------------------------------------------------------------------------
// ttriu_pkg
// Shared types, constants and helpers for the timer and raster interrupt unit.
// ----------------------------------------------------------------------------
package ttriu_pkg;

   // Operation codes carried by an input beat.
   typedef enum logic [1:0] {
      OP_ADVANCE = 2'd0,
      OP_ACK     = 2'd1,
      OP_LOAD    = 2'd2
   } op_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_ROW_CYCLES     = 3'd0,
      CSR_RASTER_LINES   = 3'd1,
      CSR_TIMER1_RELOAD  = 3'd2,
      CSR_IRQ_ENABLE     = 3'd3,
      CSR_RASTER_COMPARE = 3'd4,
      CSR_TIMERS_RUNNING = 3'd5
   } csr_index_type;

   // Flag bits of the interrupt status register.
   localparam logic [7:0] FLAG_RASTER  = 8'h02;
   localparam logic [7:0] FLAG_T1      = 8'h08;
   localparam logic [7:0] FLAG_T2      = 8'h10;
   localparam logic [7:0] FLAG_T3      = 8'h40;
   localparam logic [7:0] FLAG_IRQ     = 8'h80;
   localparam logic [7:0] FLAG_FIXED   = 8'h25;
   localparam logic [7:0] FLAG_SOURCES = 8'h5A;

   // Timer 2 and 3 reload value, and the row where the fast CPU clock starts.
   localparam logic [15:0] FREE_RELOAD = 16'hFFFF;
   localparam logic [8:0]  BORDER_ROW  = 9'd205;
   localparam logic [2:0]  SPEED_FAST  = 3'd7;
   localparam logic [2:0]  SPEED_SLOW  = 3'd5;

   // Largest value the row-cycle accumulator holds.
   localparam logic [10:0] ACC_MAX = 11'h7FF;

   // Reset values of the configuration registers.
   localparam logic [9:0]  ROW_CYCLES_RST     = 10'd57;
   localparam logic [9:0]  RASTER_LINES_RST   = 10'd312;
   localparam logic [2:0]  TIMERS_RUNNING_RST = 3'd7;

   typedef struct packed {
      logic [15:0] count;
      logic        fired;
   } count_down_type;

   // Subtract the elapsed cycles; at zero or below add the reload value.
   function automatic count_down_type count_down(input logic [15:0] count,
                                                 input logic [6:0]  sub,
                                                 input logic [15:0] add);
      logic [17:0]    diff;
      count_down_type res;
      diff = {2'b00, count} - {11'd0, sub};
      res.fired = diff[17] | (diff == 18'd0);
      res.count = res.fired ? (diff[15:0] + add) : diff[15:0];
      return res;
   endfunction

endpackage

// File: rtl/core/ted_timer_raster_interrupt_unit_top.sv
// ----------------------------------------------------------------------------
// ted_timer_raster_interrupt_unit_top
// Raster row counter, frame flash counter and three interval timers with
// their interrupt flags, driven by advance, acknowledge and load beats.
// ----------------------------------------------------------------------------
// Usage:
// Each request beat (req_*) carries one operation: advance time by a cycle
// count, acknowledge interrupt flags by mask, or load one timer counter.
// Every request beat yields exactly one response beat (rsp_*) that reports
// the flags, raster row, timer counts, flash count and CPU speed factor as
// they stand after the operation.
// The whole update is one pass of logic from the state registers into the
// state and response registers, so the response appears in the cycle after the
// request is taken, and one request is taken every cycle while req_stall is low.
// A waiting response is held in the response register; a new request is
// still taken in that cycle when the response is taken at the same edge.
// req_stall is high only while a response is held and rsp_stall is high.
// Configuration registers are written through csr_write, csr_index and
// csr_wdata at any edge; they are meant to change only while the unit is
// idle. Reset clears all counters and flags, loads the register defaults
// and empties the response register.
// ----------------------------------------------------------------------------
module ted_timer_raster_interrupt_unit_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [6:0]  req_cycles,
   input  logic [7:0]  req_ack_mask,
   input  logic [1:0]  req_timer_select,
   input  logic [15:0] req_timer_value,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_irq_sources,
   output logic [7:0]  rsp_interrupt_status,
   output logic [8:0]  rsp_raster_row,
   output logic [15:0] rsp_timer1_count,
   output logic [15:0] rsp_timer2_count,
   output logic [15:0] rsp_timer3_count,
   output logic [4:0]  rsp_flash_count,
   output logic [2:0]  rsp_cpu_speed_mul,
   // Configuration port
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers.
   logic [9:0]  row_cycles_ff;
   logic [9:0]  raster_lines_ff;
   logic [15:0] timer1_reload_ff;
   logic [7:0]  irq_enable_ff;
   logic [8:0]  raster_compare_ff;
   logic [2:0]  timers_running_ff;

   // Unit state.
   logic [10:0] acc_ff,   acc_in;
   logic [8:0]  row_ff,   row_in;
   logic [4:0]  flash_ff, flash_in;
   logic [15:0] timer_ff [3];
   logic [15:0] timer_in [3];
   logic [7:0]  flags_ff, flags_in;

   // Response register.
   logic        rsp_valid_ff;
   logic [7:0]  rsp_irq_ff;
   logic [7:0]  rsp_status_ff;
   logic [8:0]  rsp_row_ff;
   logic [15:0] rsp_t1_ff, rsp_t2_ff, rsp_t3_ff;
   logic [4:0]  rsp_flash_ff;
   logic [2:0]  rsp_speed_ff;

   logic accept;

   // A held response blocks new requests only while the receiver stalls.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_cycles_ff     <= ttriu_pkg::ROW_CYCLES_RST;
         raster_lines_ff   <= ttriu_pkg::RASTER_LINES_RST;
         timer1_reload_ff  <= '0;
         irq_enable_ff     <= '0;
         raster_compare_ff <= '0;
         timers_running_ff <= ttriu_pkg::TIMERS_RUNNING_RST;
      end else if (csr_write) begin
         unique case (ttriu_pkg::csr_index_type'(csr_index))
            ttriu_pkg::CSR_ROW_CYCLES:     row_cycles_ff     <= csr_wdata[9:0];
            ttriu_pkg::CSR_RASTER_LINES:   raster_lines_ff   <= csr_wdata[9:0];
            ttriu_pkg::CSR_TIMER1_RELOAD:  timer1_reload_ff  <= csr_wdata;
            ttriu_pkg::CSR_IRQ_ENABLE:     irq_enable_ff     <= csr_wdata[7:0];
            ttriu_pkg::CSR_RASTER_COMPARE: raster_compare_ff <= csr_wdata[8:0];
            ttriu_pkg::CSR_TIMERS_RUNNING: timers_running_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Next state for the beat on the request channel.
   always_comb begin
      logic [11:0]                acc_sum;
      logic [10:0]                acc_sat;
      logic [9:0]                 row_next;
      logic [7:0]                 flags_work;
      logic [6:0]                 t2_sub;
      ttriu_pkg::count_down_type  cd1, cd2, cd3;

      acc_in   = acc_ff;
      row_in   = row_ff;
      flash_in = flash_ff;
      flags_in = flags_ff;
      for (int i = 0; i < 3; i++) begin
         timer_in[i] = timer_ff[i];
      end

      // Row accumulator with saturation, at most one row step per beat.
      acc_sum  = {1'b0, acc_ff} + {5'd0, req_cycles};
      acc_sat  = acc_sum[11] ? ttriu_pkg::ACC_MAX : acc_sum[10:0];
      row_next = {1'b0, row_ff} + 10'd1;
      t2_sub   = timers_running_ff[0] ? req_cycles : 7'd0;
      cd1 = ttriu_pkg::count_down(timer_ff[0], req_cycles, timer1_reload_ff);
      cd2 = ttriu_pkg::count_down(timer_ff[1], t2_sub, ttriu_pkg::FREE_RELOAD);
      cd3 = ttriu_pkg::count_down(timer_ff[2], req_cycles, ttriu_pkg::FREE_RELOAD);
      flags_work = flags_ff;

      unique case (ttriu_pkg::op_type'(req_operation))
         ttriu_pkg::OP_ADVANCE: begin
            acc_in = acc_sat;
            if (acc_sat >= {1'b0, row_cycles_ff}) begin
               acc_in = acc_sat - {1'b0, row_cycles_ff};
               if (row_next >= raster_lines_ff) begin
                  row_next = '0;
                  flash_in = flash_ff + 5'd1;
               end
               if (row_next == {1'b0, raster_compare_ff}) begin
                  flags_work = flags_work | ttriu_pkg::FLAG_RASTER;
               end
               row_in = row_next[8:0];
            end
            // Timers that run count down and reload at zero; timer 2 counts only while timer 1 runs.
            if (timers_running_ff[0]) begin
               timer_in[0] = cd1.count;
               if (cd1.fired) flags_work = flags_work | ttriu_pkg::FLAG_T1;
            end
            if (timers_running_ff[1]) begin
               timer_in[1] = cd2.count;
               if (cd2.fired) flags_work = flags_work | ttriu_pkg::FLAG_T2;
            end
            if (timers_running_ff[2]) begin
               timer_in[2] = cd3.count;
               if (cd3.fired) flags_work = flags_work | ttriu_pkg::FLAG_T3;
            end
            if ((flags_work & irq_enable_ff & ttriu_pkg::FLAG_SOURCES) != 8'd0) begin
               flags_work = flags_work | ttriu_pkg::FLAG_IRQ;
            end
            flags_in = flags_work | ttriu_pkg::FLAG_FIXED;
         end
         ttriu_pkg::OP_ACK: begin
            flags_in = flags_ff &
                       ~(ttriu_pkg::FLAG_IRQ | (req_ack_mask & ttriu_pkg::FLAG_SOURCES));
         end
         ttriu_pkg::OP_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               if (req_timer_select == 2'(i)) timer_in[i] = req_timer_value;
            end
         end
         default: ;
      endcase
   end

   // State registers, updated on each accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         row_ff   <= '0;
         flash_ff <= '0;
         flags_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            timer_ff[i] <= '0;
         end
      end else if (accept) begin
         acc_ff   <= acc_in;
         row_ff   <= row_in;
         flash_ff <= flash_in;
         flags_ff <= flags_in;
         for (int i = 0; i < 3; i++) begin
            timer_ff[i] <= timer_in[i];
         end
      end
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload, loaded with the state after the beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_irq_ff    <= flags_in & irq_enable_ff & ttriu_pkg::FLAG_SOURCES;
         rsp_status_ff <= flags_in;
         rsp_row_ff    <= row_in;
         rsp_t1_ff     <= timer_in[0];
         rsp_t2_ff     <= timer_in[1];
         rsp_t3_ff     <= timer_in[2];
         rsp_flash_ff  <= flash_in;
         rsp_speed_ff  <= (row_in >= ttriu_pkg::BORDER_ROW) ? ttriu_pkg::SPEED_FAST
                                                            : ttriu_pkg::SPEED_SLOW;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_irq_sources      = rsp_irq_ff;
   assign rsp_interrupt_status = rsp_status_ff;
   assign rsp_raster_row       = rsp_row_ff;
   assign rsp_timer1_count     = rsp_t1_ff;
   assign rsp_timer2_count     = rsp_t2_ff;
   assign rsp_timer3_count     = rsp_t3_ff;
   assign rsp_flash_count      = rsp_flash_ff;
   assign rsp_cpu_speed_mul    = rsp_speed_ff;

   // Every accepted beat leaves a response in the register.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted beat produced no response");

   // An advance always leaves the fixed status bits set.
   a_advance_fixed: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == ttriu_pkg::OP_ADVANCE) |=>
      ((rsp_interrupt_status & ttriu_pkg::FLAG_FIXED) == ttriu_pkg::FLAG_FIXED))
      else $error("fixed status bits missing after advance");

   // An acknowledge always clears the summary IRQ bit.
   a_ack_clears_irq: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == ttriu_pkg::OP_ACK) |=> !rsp_interrupt_status[7])
      else $error("IRQ bit still set after acknowledge");

   // The speed factor follows the reported raster row.
   a_speed_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cpu_speed_mul == ((rsp_raster_row >= ttriu_pkg::BORDER_ROW) ?
                     ttriu_pkg::SPEED_FAST : ttriu_pkg::SPEED_SLOW)))
      else $error("speed factor does not match raster row");

   // Reported IRQ sources are always a subset of the status flags.
   a_irq_subset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_irq_sources & ~rsp_interrupt_status) == 8'd0))
      else $error("IRQ source reported without its flag");

endmodule
